// ----- sv/at_command_line_parser_macros.svh -----
// ---------------------------------------------------------------------------
// AT command line parser assertion macros
// Concurrent assertion helpers shared by the parser RTL files.
// ---------------------------------------------------------------------------
`ifndef AT_COMMAND_LINE_PARSER_MACROS_SVH
`define AT_COMMAND_LINE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define ATCL_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ATCL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ATCL_ASSERT(name, clk, rst, prop, msg)
`define ATCL_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/atcl_pkg.sv -----
// ---------------------------------------------------------------------------
// AT command line parser package
// Types, codes and keyword tables shared by the parser modules.
// ---------------------------------------------------------------------------
package atcl_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_KEY,
    PH_READ,
    PH_DIGITS,
    PH_BADVAL,
    PH_SYNTAX
  } phase_t;

  localparam logic [2:0] ST_READ   = 3'd0;
  localparam logic [2:0] ST_WRITE  = 3'd1;
  localparam logic [2:0] ST_HELP   = 3'd2;
  localparam logic [2:0] ST_SYNTAX = 3'd3;
  localparam logic [2:0] ST_VALUE  = 3'd4;

  localparam int NUM_CMDS = 7;

  localparam logic [2:0] CMD_HELP  = 3'd0;
  localparam logic [2:0] CMD_DAY   = 3'd1;
  localparam logic [2:0] CMD_DATE  = 3'd2;
  localparam logic [2:0] CMD_MONTH = 3'd3;
  localparam logic [2:0] CMD_YEAR  = 3'd4;
  localparam logic [2:0] CMD_LEAP  = 3'd5;
  localparam logic [2:0] CMD_DST   = 3'd6;
  localparam logic [2:0] CMD_NONE  = 3'd7;

  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_QUERY  = 8'h3F;
  localparam logic [7:0] CHAR_ASSIGN = 8'h3D;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;

  localparam int PREFIX_LEN = 3;
  localparam int KW_MAX_LEN = 20;

  localparam logic [15:0] YEAR_OFFSET = 16'd2000;
  localparam logic [15:0] ACC_MAX     = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       eol;
    logic       digit;
    logic [3:0] digit_val;
    logic       is_query;
    logic       is_assign;
  } token_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CHAR_A;
      2'd1:    c = CHAR_T;
      2'd2:    c = CHAR_DOLLAR;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] kw_len(input logic [2:0] cmd);
    logic [4:0] n;
    case (cmd)
      CMD_HELP:  n = 5'd4;
      CMD_DAY:   n = 5'd3;
      CMD_DATE:  n = 5'd4;
      CMD_MONTH: n = 5'd5;
      CMD_YEAR:  n = 5'd4;
      CMD_LEAP:  n = 5'd9;
      CMD_DST:   n = 5'd20;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

  // Keyword text is left aligned, so character i sits at the i-th byte from the top.
  function automatic logic [7:0] kw_char(input logic [2:0] cmd, input logic [4:0] pos);
    logic [159:0] txt;
    logic [7:0]   c;
    int           idx;
    case (cmd)
      CMD_HELP:  txt = {"HELP", 128'h0};
      CMD_DAY:   txt = {"DAY", 136'h0};
      CMD_DATE:  txt = {"DATE", 128'h0};
      CMD_MONTH: txt = {"MONTH", 120'h0};
      CMD_YEAR:  txt = {"YEAR", 128'h0};
      CMD_LEAP:  txt = {"LEAP_", "YEAR", 88'h0};
      CMD_DST:   txt = {"DAYLIGHT_", "SAVING_TIME"};
      default:   txt = '0;
    endcase
    idx = 159 - 8 * int'(pos);
    if (pos < 5'(KW_MAX_LEN)) begin
      c = txt[idx -: 8];
    end else begin
      c = 8'h00;
    end
    return c;
  endfunction

  function automatic logic [15:0] range_lo(input logic [2:0] cmd);
    logic [15:0] v;
    case (cmd)
      CMD_HELP:  v = ACC_MAX;
      CMD_DAY:   v = 16'd1;
      CMD_DATE:  v = 16'd1;
      CMD_MONTH: v = 16'd1;
      CMD_YEAR:  v = YEAR_OFFSET;
      default:   v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] range_hi(input logic [2:0] cmd);
    logic [15:0] v;
    case (cmd)
      CMD_HELP:  v = ACC_MAX;
      CMD_DAY:   v = 16'd7;
      CMD_DATE:  v = 16'd31;
      CMD_MONTH: v = 16'd12;
      CMD_YEAR:  v = 16'd2099;
      CMD_LEAP:  v = 16'd1;
      CMD_DST:   v = 16'd1;
      default:   v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/at_command_line_parser.sv -----
// ---------------------------------------------------------------------------
// AT command line parser
// Parses AT$NAME? and AT$NAME=digits lines and reports one result per non-empty line.
// ---------------------------------------------------------------------------
//   channel   handshake             payload
//   input     in_valid / in_ready   rx_byte
//   output    out_valid / out_ready status, command, value
//
// One byte is accepted per cycle while the queue has room. With an empty queue,
// the line end's token passes through the four-entry token queue and then the
// result register before out_valid rises.
// After reset the parameter store holds its defaults at once; no clearing pass.
// A stalled result holds back only the line-end token: bytes keep entering the
// queue until it fills, and then in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
module at_command_line_parser #(
  parameter int MAX_LINE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [2:0]  command,
  output logic [11:0] value
);

  atcl_pkg::token_t front_tok;
  atcl_pkg::token_t q_tok;
  logic             push;
  logic             push_ready;
  logic             q_valid;
  logic             pop;

  atcl_front u_front (
    .in_valid (in_valid),
    .rx_byte  (rx_byte),
    .in_ready (in_ready),
    .q_ready  (push_ready),
    .push     (push),
    .tok      (front_tok)
  );

  atcl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_tok   (front_tok),
    .push_ready (push_ready),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .pop        (pop)
  );

  atcl_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_tok     (q_tok),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .command   (command),
    .value     (value)
  );

endmodule

// ----- sv/atcl_front.sv -----
// ---------------------------------------------------------------------------
// AT parser front end
// Accepts received bytes and classifies each one into a token for the queue.
// ---------------------------------------------------------------------------
module atcl_front (
  input  logic              in_valid,
  input  logic [7:0]        rx_byte,
  output logic              in_ready,
  input  logic              q_ready,
  output logic              push,
  output atcl_pkg::token_t  tok
);

  logic [7:0] digit_off;

  assign in_ready  = q_ready;
  assign push      = in_valid && q_ready;
  assign digit_off = rx_byte - atcl_pkg::CHAR_ZERO;

  always_comb begin
    tok.data      = rx_byte;
    tok.eol       = (rx_byte == atcl_pkg::CHAR_LF) || (rx_byte == atcl_pkg::CHAR_CR);
    tok.digit     = (rx_byte >= atcl_pkg::CHAR_ZERO) && (rx_byte <= atcl_pkg::CHAR_NINE);
    tok.digit_val = digit_off[3:0];
    tok.is_query  = (rx_byte == atcl_pkg::CHAR_QUERY);
    tok.is_assign = (rx_byte == atcl_pkg::CHAR_ASSIGN);
  end

endmodule

// ----- sv/atcl_queue.sv -----
// ---------------------------------------------------------------------------
// AT parser token queue
// Small FIFO that decouples the classifier from the line parser.
// ---------------------------------------------------------------------------
`include "at_command_line_parser_macros.svh"

module atcl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  atcl_pkg::token_t  push_tok,
  output logic              push_ready,
  output logic              q_valid,
  output atcl_pkg::token_t  q_tok,
  input  logic              pop
);

  localparam int PTR_W = $clog2(atcl_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(atcl_pkg::QUEUE_DEPTH + 1);

  atcl_pkg::token_t mem [atcl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(atcl_pkg::QUEUE_DEPTH));
  assign q_valid    = (count != '0);
  assign q_tok      = mem[rd_ptr];
  assign do_pop     = pop && q_valid;

  always_comb begin
    count_next = count;
    if (push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (!push && do_pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  `ATCL_ASSERT(a_queue_no_overfill, clk, rst, (count <= CNT_W'(atcl_pkg::QUEUE_DEPTH)), "queue count beyond depth")
  `ATCL_ASSERT_NEXT(a_queue_drains, clk, rst, (do_pop && !push && count == CNT_W'(1)), !q_valid, "queue not empty after last pop")

endmodule

// ----- sv/atcl_back.sv -----
// ---------------------------------------------------------------------------
// AT parser back end
// Parses tokens into commands, keeps the parameter store and holds the result.
// ---------------------------------------------------------------------------
`include "at_command_line_parser_macros.svh"

module atcl_back #(
  parameter int MAX_LINE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  atcl_pkg::token_t  q_tok,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [2:0]        command,
  output logic [11:0]       value
);

  localparam int POS_W = $clog2(MAX_LINE + 1);

  atcl_pkg::phase_t phase;
  atcl_pkg::phase_t phase_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [6:0]       cand;
  logic [6:0]       cand_next;
  logic [15:0]      acc;
  logic [15:0]      acc_next;
  logic             ovf;
  logic             ovf_next;
  logic [6:0]       store [atcl_pkg::NUM_CMDS];

  atcl_pkg::phase_t ph;
  logic             out_free;
  logic             load;
  logic             store_we;
  logic [6:0]       store_wdata;
  logic [2:0]       cur_cmd;
  logic [4:0]       kp;
  logic             key_ok;
  logic [6:0]       hit;
  logic [6:0]       nxt;
  logic [6:0]       hit_first;
  logic [19:0]      acc_sum;
  logic [15:0]      year_diff;
  logic [11:0]      read_val;
  logic             syntax_err;
  logic             write_ok;
  logic [2:0]       status_next;
  logic [2:0]       command_next;
  logic [11:0]      value_next;

  assign out_free = !out_valid || out_ready;
  // A line end may only leave the queue when the result register can take it.
  assign pop      = q_valid && (!q_tok.eol || out_free);

  // Lowest set candidate is the matched command.
  always_comb begin
    cur_cmd = atcl_pkg::CMD_NONE;
    for (int k = atcl_pkg::NUM_CMDS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        cur_cmd = 3'(k);
      end
    end
  end

  always_comb begin
    ph     = (phase == atcl_pkg::PH_START) ? atcl_pkg::PH_KEY : phase;
    kp     = 5'(pos - POS_W'(atcl_pkg::PREFIX_LEN));
    key_ok = (pos >= POS_W'(atcl_pkg::PREFIX_LEN)) &&
             (pos < POS_W'(atcl_pkg::PREFIX_LEN + atcl_pkg::KW_MAX_LEN + 1));
    for (int k = 0; k < atcl_pkg::NUM_CMDS; k++) begin
      nxt[k] = cand[k] && key_ok && (kp < atcl_pkg::kw_len(3'(k))) &&
               (q_tok.data == atcl_pkg::kw_char(3'(k), kp));
      hit[k] = cand[k] && key_ok && (kp == atcl_pkg::kw_len(3'(k))) &&
               (q_tok.is_query || q_tok.is_assign);
    end
    hit_first = hit & ~(hit - 7'd1);
    acc_sum   = {acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, q_tok.digit_val};
  end

  // Next state of the line parser.
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    cand_next  = cand;
    acc_next   = acc;
    ovf_next   = ovf;
    load       = 1'b0;
    if (pop) begin
      if (q_tok.eol) begin
        load       = (phase != atcl_pkg::PH_START);
        phase_next = atcl_pkg::PH_START;
        pos_next   = '0;
        cand_next  = '1;
        acc_next   = '0;
        ovf_next   = 1'b0;
      end else begin
        phase_next = ph;
        if (pos < POS_W'(MAX_LINE)) begin
          pos_next = pos + 1'b1;
        end
        case (ph)
          atcl_pkg::PH_KEY: begin
            if (pos < POS_W'(atcl_pkg::PREFIX_LEN)) begin
              if (q_tok.data != atcl_pkg::prefix_char(pos[1:0])) begin
                phase_next = atcl_pkg::PH_SYNTAX;
              end
            end else if (hit != '0) begin
              cand_next  = hit_first;
              phase_next = q_tok.is_query ? atcl_pkg::PH_READ : atcl_pkg::PH_DIGITS;
            end else begin
              cand_next = nxt;
              if (nxt == '0) begin
                phase_next = atcl_pkg::PH_SYNTAX;
              end
            end
          end
          atcl_pkg::PH_DIGITS: begin
            if (q_tok.digit) begin
              acc_next = acc_sum[15:0];
              if (acc_sum[19:16] != '0) begin
                ovf_next = 1'b1;
              end
            end else begin
              phase_next = atcl_pkg::PH_BADVAL;
            end
          end
          default: begin
            phase_next = ph;
          end
        endcase
      end
    end
  end

  // Result of a finished line.
  always_comb begin
    year_diff   = acc - atcl_pkg::YEAR_OFFSET;
    store_wdata = (cur_cmd == atcl_pkg::CMD_YEAR) ? year_diff[6:0] : acc[6:0];
    read_val    = {5'd0, store[cur_cmd]};
    if (cur_cmd == atcl_pkg::CMD_YEAR) begin
      read_val = read_val + atcl_pkg::YEAR_OFFSET[11:0];
    end
    syntax_err = (pos >= POS_W'(MAX_LINE)) || (phase == atcl_pkg::PH_KEY) ||
                 (phase == atcl_pkg::PH_SYNTAX) || (cur_cmd == atcl_pkg::CMD_NONE);
    write_ok   = (phase == atcl_pkg::PH_DIGITS) && !ovf &&
                 (acc >= atcl_pkg::range_lo(cur_cmd)) && (acc <= atcl_pkg::range_hi(cur_cmd));
    store_we     = 1'b0;
    status_next  = atcl_pkg::ST_VALUE;
    command_next = cur_cmd;
    value_next   = '0;
    if (syntax_err) begin
      status_next  = atcl_pkg::ST_SYNTAX;
      command_next = atcl_pkg::CMD_NONE;
    end else if (phase == atcl_pkg::PH_READ) begin
      if (cur_cmd == atcl_pkg::CMD_HELP) begin
        status_next = atcl_pkg::ST_HELP;
      end else begin
        status_next = atcl_pkg::ST_READ;
        value_next  = read_val;
      end
    end else if (write_ok) begin
      if (cur_cmd == atcl_pkg::CMD_HELP) begin
        status_next = atcl_pkg::ST_HELP;
      end else begin
        status_next = atcl_pkg::ST_WRITE;
        value_next  = acc[11:0];
        store_we    = load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= atcl_pkg::PH_START;
      pos       <= '0;
      cand      <= '1;
      acc       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
      cand  <= cand_next;
      acc   <= acc_next;
      ovf   <= ovf_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status  <= status_next;
      command <= command_next;
      value   <= value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < atcl_pkg::NUM_CMDS; k++) begin
        store[k] <= ((k == int'(atcl_pkg::CMD_DAY)) || (k == int'(atcl_pkg::CMD_DATE)) ||
                     (k == int'(atcl_pkg::CMD_MONTH))) ? 7'd1 : 7'd0;
      end
    end else if (store_we) begin
      store[cur_cmd] <= store_wdata;
    end
  end

  `ATCL_ASSERT(a_single_match, clk, rst, ((phase == atcl_pkg::PH_READ || phase == atcl_pkg::PH_DIGITS || phase == atcl_pkg::PH_BADVAL) |-> $onehot(cand)), "matched line has no single command")
  `ATCL_ASSERT_NEXT(a_line_cleared, clk, rst, load, (phase == atcl_pkg::PH_START && acc == '0 && !ovf), "line state not cleared after result")
  `ATCL_ASSERT(a_pos_saturates, clk, rst, (pos <= POS_W'(MAX_LINE)), "line position beyond limit")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AT command line parser testbench
// Streams directed and random command lines into the parser, predicts each
// line's reply with a behavioral parser of its own, and checks every reply
// transfer field by field while both handshakes idle in random bursts.
// ---------------------------------------------------------------------------
module tb;

  localparam int MAX_LINE_LEN = 64;
  localparam int TAIL_ITEMS   = 150;
  localparam int RANDOM_ITEMS = 1750;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  command;
    logic [11:0] value;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [2:0]  command;
  logic [11:0] value;

  at_command_line_parser #(.MAX_LINE(MAX_LINE_LEN)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .command(command), .value(value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Keyword text and write ranges, indexed by command code.
  string kw_name [atcl_pkg::NUM_CMDS] = '{"HELP", "DAY", "DATE", "MONTH", "YEAR",
                                          {"LEAP_", "YEAR"},
                                          {"DAYLIGHT_", "SAVING_TIME"}};
  int    cmd_lo  [atcl_pkg::NUM_CMDS] = '{65535, 1, 1, 1, 2000, 0, 0};
  int    cmd_hi  [atcl_pkg::NUM_CMDS] = '{65535, 7, 31, 12, 2099, 1, 1};
  string at_prefix = "AT$";

  // Parser state mirrored by the prediction.
  atcl_pkg::phase_t line_phase;
  int               line_len;
  logic [6:0]       kw_match;
  int               num_acc;
  bit               num_ovf;
  logic [6:0]       param_mem [atcl_pkg::NUM_CMDS];

  logic [7:0] rx_pending [$];
  logic [7:0] line_buf [$];
  reply_t     pending_replies [$];
  int         errors = 0;
  int         rx_total = 0;

  bit rx_taken = 1'b0;
  int rx_gap = 0;
  int rx_gap_pct = 20;
  int out_gap = 0;
  int out_gap_pct = 20;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic clear_line();
    line_phase = atcl_pkg::PH_START;
    line_len   = 0;
    kw_match   = 7'h7F;
    num_acc    = 0;
    num_ovf    = 1'b0;
  endtask

  task automatic reset_model();
    clear_line();
    for (int k = 0; k < atcl_pkg::NUM_CMDS; k++) param_mem[k] = 7'd0;
    param_mem[atcl_pkg::CMD_DAY]   = 7'd1;
    param_mem[atcl_pkg::CMD_DATE]  = 7'd1;
    param_mem[atcl_pkg::CMD_MONTH] = 7'd1;
  endtask

  // Advances the mirrored parser by one byte and queues the reply a line end causes.
  task automatic parse_byte(input logic [7:0] b);
    int         c;
    int         p;
    int         kp;
    bit         hit;
    logic [6:0] nxt;
    reply_t     r;
    if (b == atcl_pkg::CHAR_LF || b == atcl_pkg::CHAR_CR) begin
      if (line_phase != atcl_pkg::PH_START) begin
        c = atcl_pkg::NUM_CMDS;
        for (int k = 0; k < atcl_pkg::NUM_CMDS; k++) begin
          if (c == atcl_pkg::NUM_CMDS && kw_match[k]) c = k;
        end
        r.status  = atcl_pkg::ST_VALUE;
        r.command = atcl_pkg::CMD_NONE;
        r.value   = 12'd0;
        if (line_len >= MAX_LINE_LEN || line_phase == atcl_pkg::PH_KEY ||
            line_phase == atcl_pkg::PH_SYNTAX || c >= atcl_pkg::NUM_CMDS) begin
          r.status = atcl_pkg::ST_SYNTAX;
        end else if (line_phase == atcl_pkg::PH_READ) begin
          r.command = 3'(c);
          if (c == int'(atcl_pkg::CMD_HELP)) begin
            r.status = atcl_pkg::ST_HELP;
          end else begin
            r.status = atcl_pkg::ST_READ;
            r.value  = 12'(int'(param_mem[c]) + (c == int'(atcl_pkg::CMD_YEAR) ? 2000 : 0));
          end
        end else if (line_phase == atcl_pkg::PH_DIGITS && !num_ovf && num_acc >= cmd_lo[c] &&
                     num_acc <= cmd_hi[c]) begin
          r.command = 3'(c);
          if (c == int'(atcl_pkg::CMD_HELP)) begin
            r.status = atcl_pkg::ST_HELP;
          end else begin
            r.status = atcl_pkg::ST_WRITE;
            r.value  = 12'(num_acc);
            param_mem[c] = 7'(c == int'(atcl_pkg::CMD_YEAR) ? num_acc - 2000 : num_acc);
          end
        end else begin
          r.command = 3'(c);
        end
        pending_replies.push_back(r);
        clear_line();
      end
    end else begin
      if (line_phase == atcl_pkg::PH_START) begin
        clear_line();
        line_phase = atcl_pkg::PH_KEY;
      end
      p = line_len;
      if (line_len < MAX_LINE_LEN) line_len++;
      case (line_phase)
        atcl_pkg::PH_KEY: begin
          if (p < 3) begin
            if (b != at_prefix[p]) line_phase = atcl_pkg::PH_SYNTAX;
          end else begin
            kp  = p - 3;
            nxt = 7'd0;
            hit = 1'b0;
            // The first candidate whose keyword is complete takes the request mark.
            for (int k = 0; k < atcl_pkg::NUM_CMDS; k++) begin
              if (!hit && kw_match[k]) begin
                if (kp < kw_name[k].len()) begin
                  if (b == kw_name[k][kp]) nxt[k] = 1'b1;
                end else if (kp == kw_name[k].len() &&
                             (b == atcl_pkg::CHAR_QUERY || b == atcl_pkg::CHAR_ASSIGN)) begin
                  kw_match   = 7'd1 << k;
                  line_phase = (b == atcl_pkg::CHAR_QUERY) ? atcl_pkg::PH_READ :
                                                             atcl_pkg::PH_DIGITS;
                  hit        = 1'b1;
                end
              end
            end
            if (!hit) begin
              kw_match = nxt;
              if (nxt == 7'd0) line_phase = atcl_pkg::PH_SYNTAX;
            end
          end
        end
        atcl_pkg::PH_DIGITS: begin
          if (b >= atcl_pkg::CHAR_ZERO && b <= atcl_pkg::CHAR_NINE) begin
            num_acc = num_acc * 10 + int'(b - atcl_pkg::CHAR_ZERO);
            if (num_acc > 65535) begin
              num_ovf = 1'b1;
              num_acc = num_acc & 65535;
            end
          end else begin
            line_phase = atcl_pkg::PH_BADVAL;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] any_but_eol();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == atcl_pkg::CHAR_LF || b == atcl_pkg::CHAR_CR) b = 8'hFF;
    return b;
  endfunction

  // Appends a random line end and moves the line into the transmit queue.
  task automatic end_line();
    int t;
    t = $urandom_range(0, 2);
    if (t != 0) line_buf.push_back(atcl_pkg::CHAR_CR);
    if (t != 1) line_buf.push_back(atcl_pkg::CHAR_LF);
    while (line_buf.size() > 0) begin
      rx_pending.push_back(line_buf.pop_front());
      rx_total++;
    end
  endtask

  task automatic send_line(input string s);
    add_text(s);
    end_line();
  endtask

  task automatic add_write_value(input int cmd);
    int    sel;
    int    v;
    string digits;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      digits = $sformatf("%0d", $urandom_range(cmd_lo[cmd], cmd_hi[cmd]));
      if ($urandom_range(0, 4) == 0) digits = {"0", digits};
      add_text(digits);
    end else if (sel < 75) begin
      v = ($urandom_range(0, 1) == 0) ? cmd_lo[cmd] - 1 : cmd_hi[cmd] + 1;
      if (v < 0) v = cmd_hi[cmd] + 1;
      add_text($sformatf("%0d", v));
    end else if (sel < 85) begin
      add_text($sformatf("%0d", $urandom_range(0, 999999)));
    end else if (sel < 88) begin
      // Nothing after the assign mark.
    end else if (sel < 93) begin
      repeat ($urandom_range(6, 10)) begin
        line_buf.push_back(8'(atcl_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      end
    end else begin
      add_text($sformatf("%0d", $urandom_range(cmd_lo[cmd], cmd_hi[cmd])));
      case ($urandom_range(0, 4))
        0:       line_buf.push_back(8'h2F);
        1:       line_buf.push_back(8'h3A);
        2:       line_buf.push_back(8'h20);
        3:       line_buf.push_back(8'h2D);
        default: line_buf.push_back(any_but_eol());
      endcase
      if ($urandom_range(0, 1) == 0) add_text("5");
    end
  endtask

  // Mostly well-formed commands with random content, the rest broken lines and noise.
  task automatic gen_random_line();
    int kind;
    int cmd;
    int n;
    kind = $urandom_range(0, 99);
    cmd  = $urandom_range(0, atcl_pkg::NUM_CMDS - 1);
    if (kind < 85) begin
      add_text({"AT$", kw_name[cmd]});
      if ($urandom_range(0, 2) == 0) begin
        add_text("?");
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 5)) line_buf.push_back(any_but_eol());
        end
      end else begin
        add_text("=");
        add_write_value(cmd);
      end
      if (kind >= 60 && kind < 75) begin
        n = $urandom_range(0, line_buf.size() - 1);
        line_buf[n] = 8'($urandom_range(0, 255));
      end else if (kind >= 75) begin
        n = $urandom_range(1, line_buf.size() - 1);
        while (line_buf.size() > n) void'(line_buf.pop_back());
      end
    end else if (kind < 93) begin
      repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_text({"AT$", kw_name[cmd], "?"});
      n = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(MAX_LINE_LEN - 2, MAX_LINE_LEN + 1);
      while (line_buf.size() < n) line_buf.push_back(any_but_eol());
    end
    end_line();
    if ($urandom_range(0, 19) == 0) rx_pending.push_back(atcl_pkg::CHAR_CR);
  endtask

  task automatic load_directed();
    send_line("AT$HELP?");
    send_line("AT$HELP=65535");
    send_line("AT$HELP=1");
    send_line("AT$DAY=7");
    send_line("AT$DAY?");
    send_line("AT$DATE=31");
    send_line("AT$MONTH=12");
    send_line("AT$YEAR=2099");
    send_line("AT$YEAR?");
    send_line("AT$YEAR=2000");
    send_line({"AT$LEAP_", "YEAR=1"});
    send_line({"AT$DAYLIGHT_", "SAVING_TIME=1"});
    send_line({"AT$DAYLIGHT_", "SAVING_TIME?"});
    send_line("AT$DAY=0");
    send_line("AT$DATE=");
    send_line("AT$MONTH=1x");
    send_line("AT$DAY=65537");
    send_line("AT$DATE?junk");
    // A bare line end gives no reply.
    rx_pending.push_back(atcl_pkg::CHAR_LF);
    send_line("AT$FOO?");
    send_line("AT$DAY");
    send_line("XT$DAY?");
    add_text("AT$DAY?");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    end_line();
    line_buf.push_back(8'h00);
    add_text("AT$DAY?");
    end_line();
    add_text("AT$MONTH?");
    while (line_buf.size() < MAX_LINE_LEN) line_buf.push_back(8'h2E);
    end_line();
  endtask

  // Byte driver: holds each byte until its transfer, idling in random bursts.
  always @(negedge clk) begin : rx_drive
    logic       v;
    logic [7:0] d;
    if (!rst) begin
      v = in_valid;
      d = rx_byte;
      if (in_valid && rx_taken) begin
        v = 1'b0;
        rx_taken = 1'b0;
      end
      if (!v) begin
        if (rx_gap > 0) begin
          rx_gap--;
        end else if (rx_pending.size() > 0) begin
          if (rx_pending.size() > TAIL_ITEMS && $urandom_range(0, 99) < rx_gap_pct) begin
            rx_gap = $urandom_range(1, 12) - 1;
          end else begin
            v = 1'b1;
            d = rx_pending.pop_front();
            if ($urandom_range(0, 99) == 0) begin
              case ($urandom_range(0, 3))
                0:       rx_gap_pct = 0;
                1:       rx_gap_pct = 5;
                2:       rx_gap_pct = 20;
                default: rx_gap_pct = 40;
              endcase
            end
          end
        end
      end
      in_valid <= v;
      rx_byte  <= d;
    end
  end

  // Reply side backpressure, also in bursts, and none near the end.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (rx_pending.size() > TAIL_ITEMS && $urandom_range(0, 99) < out_gap_pct) begin
        out_gap = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) == 0) out_gap_pct = 10 * $urandom_range(0, 4);
      end
    end
  end

  // Monitor: checks reply transfers and feeds accepted bytes to the prediction.
  always @(posedge clk) begin : monitor
    reply_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected reply status %0d command %0d value %0d",
                                    status, command, value));
        end else begin
          want = pending_replies.pop_front();
          if (status !== want.status || command !== want.command || value !== want.value)
            report_mismatch($sformatf("got status %0d command %0d value %0d, want %0d %0d %0d",
                                      status, command, value,
                                      want.status, want.command, want.value));
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(rx_byte);
        rx_taken = 1'b1;
      end
    end
  end

  initial begin
    reset_model();
    load_directed();
    while (rx_total < RANDOM_ITEMS) gen_random_line();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    while (rx_pending.size() != 0 || in_valid) @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
